// ----- rtl/core/fisr_pkg.sv -----
package fisr_pkg;

    localparam int unsigned NUM_STAGES = 15;
    localparam int unsigned MANT_W     = 50;

    localparam logic [31:0] GUESS_MAGIC = 32'h5F40_0000;
    localparam logic [31:0] FP_HALF     = 32'h3F00_0000;
    localparam logic [31:0] FP_ONE_HALF = 32'h3FC0_0000;
    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_GUESS_MUL,
        OP_MUL,
        OP_ADD,
        OP_NORM,
        OP_ROUND
    } t_op;

    // unrounded value: mant * 2^(ex - (MANT_W-1)), or a finished special pattern
    typedef struct packed {
        logic                     spec;
        logic [31:0]              sbits;
        logic                     sign;
        logic signed [10:0]       ex;
        logic [MANT_W-1:0]        mant;
    } t_unr;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] acc;
        t_unr        u;
    } t_stage;

    function automatic t_op stage_op(int k);
        t_op op;
        op = OP_NORM;
        if (k == 0) begin
            op = OP_GUESS_MUL;
        end else if (k == 9) begin
            op = OP_ADD;
        end else if (k % 3 == 0) begin
            op = OP_MUL;
        end else if (k % 3 == 2) begin
            op = OP_ROUND;
        end
        return op;
    endfunction

    function automatic t_unr fmul_pre(logic [31:0] a, logic [31:0] b);
        t_unr               r;
        logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
        logic [23:0]        sa, sb;
        logic signed [10:0] ea, eb;
        logic [47:0]        p;
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        sgn    = a[31] ^ b[31];
        sa     = {a[30:23] != 8'd0, a[22:0]};
        sb     = {b[30:23] != 8'd0, b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, a[30:23]});
        eb     = (b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, b[30:23]});
        p      = sa * sb;
        r.spec  = nan_a | nan_b | inf_a | inf_b;
        r.sbits = (nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a)) ?
                  FP_QNAN : {sgn, 8'hFF, 23'd0};
        r.sign  = sgn;
        r.ex    = ea + eb - 11'sd253;
        r.mant  = {p, 2'b00};
        return r;
    endfunction

    function automatic t_unr fadd_pre(logic [31:0] a, logic [31:0] b);
        t_unr               r;
        logic               nan_a, nan_b, inf_a, inf_b, swap, sg_big, sg_sml;
        logic [23:0]        sa, sb, s_big, s_sml;
        logic [7:0]         ea, eb, e_big, e_sml, d;
        logic [5:0]         sh;
        logic [MANT_W-1:0]  am, b0, bs, m;
        logic               stk, sgn;
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        sa     = {a[30:23] != 8'd0, a[22:0]};
        sb     = {b[30:23] != 8'd0, b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        swap   = eb > ea;
        e_big  = swap ? eb : ea;
        e_sml  = swap ? ea : eb;
        s_big  = swap ? sb : sa;
        s_sml  = swap ? sa : sb;
        sg_big = swap ? b[31] : a[31];
        sg_sml = swap ? a[31] : b[31];
        d      = e_big - e_sml;
        sh     = (d > 8'd63) ? 6'd63 : d[5:0];
        am     = {1'b0, s_big, 25'd0};
        b0     = {1'b0, s_sml, 25'd0};
        bs     = b0 >> sh;
        // bits shifted out are jammed into the lsb
        stk    = |(b0 & ~({MANT_W{1'b1}} << sh));
        bs[0]  = bs[0] | stk;
        if (sg_big == sg_sml) begin
            m   = am + bs;
            sgn = sg_big;
        end else if (am >= bs) begin
            m   = am - bs;
            sgn = sg_big;
        end else begin
            m   = bs - am;
            sgn = sg_sml;
        end
        if (m == '0) begin
            sgn = a[31] & b[31];
        end
        r.spec  = nan_a | nan_b | inf_a | inf_b;
        if (nan_a | nan_b | (inf_a & inf_b & (a[31] != b[31]))) begin
            r.sbits = FP_QNAN;
        end else if (inf_a) begin
            r.sbits = a;
        end else begin
            r.sbits = b;
        end
        r.sign  = sgn;
        r.ex    = $signed({3'b000, e_big}) - 11'sd126;
        r.mant  = m;
        return r;
    endfunction

    function automatic t_unr fnorm(t_unr u);
        t_unr       r;
        logic [5:0] lz;
        r  = u;
        lz = 6'd0;
        for (int i = 0; i < MANT_W; i++) begin
            if (u.mant[i]) lz = 6'(MANT_W - 1 - i);
        end
        r.mant = u.mant << lz;
        r.ex   = u.ex - $signed({5'b00000, lz});
        return r;
    endfunction

    function automatic logic [31:0] fround(t_unr u);
        logic signed [10:0] be, shv;
        logic [5:0]         sh;
        logic [MANT_W-1:0]  ms;
        logic [23:0]        kept;
        logic               guard, stk, rup;
        logic [7:0]         ef;
        logic [30:0]        body;
        logic [31:0]        res;
        be    = u.ex + 11'sd127;
        shv   = 11'sd1 - be;
        sh    = (be >= 11'sd1) ? 6'd0 : ((shv > 11'sd63) ? 6'd63 : shv[5:0]);
        ms    = u.mant >> sh;
        kept  = ms[MANT_W-1 -: 24];
        guard = ms[MANT_W-25];
        stk   = (|ms[MANT_W-26:0]) | (|(u.mant & ~({MANT_W{1'b1}} << sh)));
        rup   = guard & (stk | kept[0]);
        ef    = (be >= 11'sd1) ? be[7:0] : 8'd0;
        // carry out of the fraction moves into the exponent field
        body  = {ef, kept[22:0]} + {30'd0, rup};
        if (u.spec) begin
            res = u.sbits;
        end else if (u.mant == '0) begin
            res = {u.sign, 31'd0};
        end else if (be >= 11'sd255) begin
            res = {u.sign, 8'hFF, 23'd0};
        end else begin
            res = {u.sign, body};
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/fast_inverse_square_root.sv -----
// throughput: one item per cycle; every stage holds its item while the next one is full
// five float operations (four multiplies, one add), each split into prepare,
// normalize and round stages
// reset: synchronous active low, clears all stage valid bits

module fast_inverse_square_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_bits
);

    localparam int unsigned NS = fisr_pkg::NUM_STAGES;

    logic             s_vld [NS+1];
    logic             s_rdy [NS+1];
    fisr_pkg::t_stage s_dat [NS+1];

    always_comb begin
        s_dat[0]     = '0;
        s_dat[0].acc = i_value_bits;
    end

    assign s_vld[0]  = i_valid;
    assign o_ready   = s_rdy[0];
    assign s_rdy[NS] = i_ready;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        fisr_stage #(
            .OP (fisr_pkg::stage_op(g))
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_vld[g]),
            .o_ready (s_rdy[g]),
            .i_data  (s_dat[g]),
            .o_valid (s_vld[g+1]),
            .i_ready (s_rdy[g+1]),
            .o_data  (s_dat[g+1])
        );
    end

    assign o_valid       = s_vld[NS];
    assign o_result_bits = s_dat[NS].acc;

endmodule

// ----- rtl/core/fisr_stage.sv -----
module fisr_stage #(
    parameter fisr_pkg::t_op OP = fisr_pkg::OP_NORM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fisr_pkg::t_stage  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output fisr_pkg::t_stage  o_data
);

    logic             r_vld;
    fisr_pkg::t_stage r_dat;
    fisr_pkg::t_stage n_dat;

    always_comb begin
        n_dat = i_data;
        case (OP)
            fisr_pkg::OP_GUESS_MUL: begin
                n_dat.y = fisr_pkg::GUESS_MAGIC - (i_data.acc >> 1);
                n_dat.u = fisr_pkg::fmul_pre(i_data.acc, fisr_pkg::FP_HALF);
            end
            fisr_pkg::OP_MUL: begin
                n_dat.u = fisr_pkg::fmul_pre(i_data.acc, i_data.y);
            end
            fisr_pkg::OP_ADD: begin
                n_dat.u = fisr_pkg::fadd_pre(fisr_pkg::FP_ONE_HALF,
                                             i_data.acc ^ fisr_pkg::SIGN_BIT);
            end
            fisr_pkg::OP_NORM: begin
                n_dat.u = fisr_pkg::fnorm(i_data.u);
            end
            fisr_pkg::OP_ROUND: begin
                n_dat.acc = fisr_pkg::fround(i_data.u);
            end
            default: begin
                n_dat = i_data;
            end
        endcase
    end

    // stage takes a new item when empty or when its item moves on
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dat <= n_dat;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_dat;

endmodule

// ----- rtl/core/fisr_checker.sv -----
module fisr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_result_bits
);

    // a stalled item keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_bits))
        else $error("result changed while stalled");

    // any nan leaves as the canonical quiet pattern
    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_bits[30:23] == 8'hFF) && (o_result_bits[22:0] != 23'd0)
        |-> o_result_bits == fisr_pkg::FP_QNAN)
        else $error("non-canonical nan on output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // with the output drained an input is always taken
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && i_valid && $past(i_rst_n) && !$past(o_valid) && !$past(i_valid)
        |-> o_ready)
        else $error("input refused with empty output");

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_bits (o_result_bits)
);

// ----- bench/tb_top.sv -----
module tb_top;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [31:0] F_HALF      = 32'h3F00_0000;
    localparam logic [31:0] F_THREE_HALVES = 32'h3FC0_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value_bits = 32'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_bits;

    logic [31:0] rsqrt_expected[$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    bit          fast_sender = 1'b0;
    bit          fast_receiver = 1'b0;

    fast_inverse_square_root i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value_bits (i_value_bits),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_bits(o_result_bits)
    );

    always #6 i_clk = ~i_clk;

    // round sign * mag * 2^ex to single precision, nearest even; mag is nonzero
    function automatic logic [31:0] round_single(logic sgn, logic [63:0] mag, int ex);
        int          msb, lsb_ex, sh, biased;
        logic [63:0] kept;
        logic        guard, sticky;
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) msb = i;
        end
        lsb_ex = msb + ex - 23;
        if (lsb_ex < -149) lsb_ex = -149;
        sh = lsb_ex - ex;
        guard = 1'b0;
        sticky = 1'b0;
        if (sh <= 0) begin
            kept = mag << (-sh);
        end else if (sh < 64) begin
            kept = mag >> sh;
            guard = mag[sh-1];
            sticky = |(mag & ((64'd1 << (sh - 1)) - 64'd1));
        end else if (sh == 64) begin
            kept = 64'd0;
            guard = mag[63];
            sticky = |mag[62:0];
        end else begin
            kept = 64'd0;
            sticky = 1'b1;
        end
        if (guard && (sticky || kept[0])) kept = kept + 64'd1;
        if (kept[24]) begin
            kept = kept >> 1;
            lsb_ex++;
        end
        if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
        biased = lsb_ex + 150;
        if (biased >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, biased[7:0], kept[22:0]};
    endfunction

    function automatic bit is_nan(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic bit is_inf(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] == 23'd0;
    endfunction

    function automatic logic [23:0] sig_of(logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic int exp_of(logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
        logic sgn;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return fisr_pkg::FP_QNAN;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
            return fisr_pkg::FP_QNAN;
        if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
        return round_single(sgn, 64'(sig_of(a)) * 64'(sig_of(b)), exp_of(a) + exp_of(b));
    endfunction

    function automatic logic [31:0] single_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] big, sml;
        logic [63:0] mb, ms, sum;
        logic        sgn, stk;
        int          d;
        if (is_nan(a) || is_nan(b)) return fisr_pkg::FP_QNAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fisr_pkg::FP_QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (exp_of(b) > exp_of(a)) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        d = exp_of(big) - exp_of(sml);
        mb = 64'(sig_of(big)) << 30;
        ms = 64'(sig_of(sml)) << 30;
        // bits shifted out of the smaller operand fold into a sticky lsb
        if (d >= 60) begin
            stk = ms != 64'd0;
            ms = 64'd0;
        end else begin
            stk = |(ms & ((64'd1 << d) - 64'd1));
            ms = ms >> d;
        end
        ms[0] = ms[0] | stk;
        if (big[31] == sml[31]) begin
            sum = mb + ms;
            sgn = big[31];
        end else if (mb >= ms) begin
            sum = mb - ms;
            sgn = big[31];
        end else begin
            sum = ms - mb;
            sgn = sml[31];
        end
        if (sum == 64'd0) return 32'd0;
        return round_single(sgn, sum, exp_of(big) - 30);
    endfunction

    function automatic logic [31:0] predict_rsqrt(logic [31:0] x);
        logic [31:0] y, h, t, d, r;
        y = fisr_pkg::GUESS_MAGIC - (x >> 1);
        h = single_mul(x, F_HALF);
        t = single_mul(h, y);
        t = single_mul(t, y);
        d = single_add(F_THREE_HALVES, {~t[31], t[30:0]});
        r = single_mul(y, d);
        if (is_nan(r)) r = fisr_pkg::FP_QNAN;
        return r;
    endfunction

    function automatic int unsigned draw_gap(bit fast);
        if (fast) return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_operand(logic [31:0] x);
        int unsigned gap;
        gap = draw_gap(fast_sender);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value_bits <= x;
        do @(posedge i_clk); while (!o_ready);
        rsqrt_expected.push_back(predict_rsqrt(x));
    endtask

    task automatic test_special_operands();
        logic [31:0] pats[$];
        pats = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000,
                 32'h4080_0000, 32'hBF80_0000, 32'hC000_0000, 32'hFFFF_FFFE,
                 32'hBE80_0002, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002,
                 32'h3E80_0000, 32'h7000_0000};
        foreach (pats[i]) send_operand(pats[i]);
    endtask

    task automatic test_random_operands(int unsigned count);
        logic [31:0] x;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                fast_sender = $urandom_range(0, 3) == 0;
                fast_receiver = $urandom_range(0, 3) == 0;
            end
            case ($urandom_range(0, 5))
                0: x = $urandom;
                1: x = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
                2: x = {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
                3: x = {1'($urandom), 8'd0, 23'($urandom)};
                4: x = {1'($urandom), 8'hFF, ($urandom_range(0, 1) == 0) ? 23'd0 : 23'($urandom)};
                default: x = {1'b1, 31'($urandom)};
            endcase
            send_operand(x);
        end
        i_valid <= 1'b0;
    endtask

    // receiver with random stalls, checks each accepted result
    always @(posedge i_clk) begin
        int unsigned stall;
        logic [31:0] want;
        if (i_rst_n && i_ready && o_valid) begin
            if (rsqrt_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %h", o_result_bits);
            end else begin
                want = rsqrt_expected.pop_front();
                if (want !== o_result_bits) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result_bits mismatch: expected %h actual %h",
                                 want, o_result_bits);
                end
            end
            stall = draw_gap(fast_receiver);
        end else if (stall > 0) begin
            stall--;
        end
        i_ready <= i_rst_n && stall == 0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_operands();
        test_random_operands(850);
        while (rsqrt_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && rsqrt_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/fisr_pkg.sv
rtl/core/fisr_stage.sv
rtl/core/fast_inverse_square_root.sv
rtl/core/fisr_checker.sv
bench/tb_top.sv
